// ===== hdl/pslex_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pslex_pkg;

  // Token kinds reported on token_kind.
  localparam logic [5:0] K_ERROR   = 6'd0;
  localparam logic [5:0] K_END     = 6'd1;
  localparam logic [5:0] K_COMMENT = 6'd2;
  localparam logic [5:0] K_NUMBER  = 6'd3;
  localparam logic [5:0] K_IDENT   = 6'd4;
  localparam logic [5:0] K_CHAR    = 6'd5;
  localparam logic [5:0] K_KW0     = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd26;
  localparam logic [5:0] K_MINUS   = 6'd27;
  localparam logic [5:0] K_STAR    = 6'd28;
  localparam logic [5:0] K_SEMI    = 6'd29;
  localparam logic [5:0] K_COLON   = 6'd30;
  localparam logic [5:0] K_ASSIGN  = 6'd31;
  localparam logic [5:0] K_LPAR    = 6'd32;
  localparam logic [5:0] K_RPAR    = 6'd33;
  localparam logic [5:0] K_DOT     = 6'd34;
  localparam logic [5:0] K_COMMA   = 6'd35;
  localparam logic [5:0] K_EQ      = 6'd36;
  localparam logic [5:0] K_GT      = 6'd37;
  localparam logic [5:0] K_GE      = 6'd38;
  localparam logic [5:0] K_LT      = 6'd39;
  localparam logic [5:0] K_NE      = 6'd40;
  localparam logic [5:0] K_LE      = 6'd41;

  // Largest exponent that scaling honors.
  localparam logic [5:0] EXP_CAP = 6'd63;

  // Output field widths.
  localparam int TOKEN_VALUE_W = 32;
  localparam int LINE_NUMBER_W = 16;

  // Keyword table: right-justified strings and their lengths.
  localparam int KW_COUNT = 20;
  localparam int KW_SPAN  = 8;
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    "program", "var", "begin", "end", "if", "then", "else", "while", "do",
    "read", "write", "char", "integer", "boolean", "div", "or", "and",
    "not", "true", "false"
  };
  localparam int KW_LEN [KW_COUNT] = '{
    7, 3, 5, 3, 2, 4, 4, 5, 2, 4, 5, 4, 7, 7, 3, 2, 3, 3, 4, 5
  };

  // Source of token_value for a result.
  typedef enum logic [1:0] {
    VS_ZERO  = 2'd0,
    VS_NUM   = 2'd1,
    VS_CHAR  = 2'd2,
    VS_IDENT = 2'd3
  } val_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_byte;
    logic       emit;
    logic [5:0] kind;
    val_sel_t   vsel;
    logic       last;
    logic       mant_start;
    logic       mant_acc;
    logic       exp_load;
    logic       exp_acc;
    logic       scale_step;
    logic       id_start;
    logic       id_push;
    logic       run_clear;
    logic       run_step;
    logic       char_load;
    logic       line_inc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       out_free;
    logic       exp_zero;
    logic       id_full;
    logic       run_last;
    logic [5:0] kw_kind;
  } status_t;

  // Returns the keyword kind for the stored identifier, or K_IDENT if none.
  // Byte j of chars sits at bits [8j+7:8j].
  function automatic logic [5:0] kw_lookup(input logic [63:0] chars,
                                           input logic [5:0]  len);
    logic [5:0] res;
    logic       hit;
    int         k;
    int         j;
    res = K_IDENT;
    for (k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (len == 6'(KW_LEN[k]));
      for (j = 0; j < KW_SPAN; j++) begin
        if (j < KW_LEN[k]) begin
          if (chars[8*j +: 8] != KW_STR[k][8*(KW_LEN[k]-1-j) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        res = K_KW0 + 6'(k);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pslex_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pslex_dp #(
  parameter int MAX_ID_LEN  = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int LINE_WIDTH  = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [7:0]            in_byte,
  input  wire                  cfg_write,
  input  wire [15:0]           cfg_data,
  input  wire                  out_stall,
  input  pslex_pkg::cmd_t      cmd,
  output pslex_pkg::status_t   status,
  output logic                 out_valid,
  output logic [5:0]           token_kind,
  output logic [15:0]          line_number,
  output logic [31:0]          token_value,
  output logic [7:0]           id_char,
  output logic                 last
);
  import pslex_pkg::*;

  localparam int IDX_W = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_ID_LEN + 1);

  logic [7:0]             byte_reg;
  logic [LINE_WIDTH-1:0]  line_count;
  logic [7:0]             ident_chars [MAX_ID_LEN];
  logic [LEN_W-1:0]       ident_length;
  logic [IDX_W-1:0]       run_idx;
  logic [VALUE_WIDTH-1:0] mantissa;
  logic [5:0]             exponent_count;
  logic [7:0]             char_literal;
  logic [3:0]             digit;
  logic [9:0]             exp_mul;
  logic [63:0]            kw_chars;
  logic [7:0]             run_char;

  assign digit    = byte_reg[3:0];
  assign exp_mul  = 10'({exponent_count, 3'b000}) + 10'({exponent_count, 1'b0}) + 10'(digit);
  assign run_char = ident_chars[run_idx];

  // Leading identifier bytes for the keyword compare.
  for (genvar j = 0; j < KW_SPAN; j++) begin : g_kw
    if (j < MAX_ID_LEN) begin : g_have
      assign kw_chars[8*j +: 8] = ident_chars[j];
    end else begin : g_none
      assign kw_chars[8*j +: 8] = 8'h00;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.byte_val = byte_reg;
    status.out_free = !out_valid || !out_stall;
    status.exp_zero = (exponent_count == 6'd0);
    status.id_full  = (ident_length == LEN_W'(MAX_ID_LEN));
    status.run_last = ((LEN_W'(run_idx) + LEN_W'(1)) == ident_length);
    status.kw_kind  = kw_lookup(kw_chars, 6'(ident_length));
  end

  // Line counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= LINE_WIDTH'(1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        line_count <= LINE_WIDTH'(cfg_data);
      end else if (cmd.line_inc && (line_count != '1)) begin
        line_count <= line_count + LINE_WIDTH'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Token registers and the identifier store.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_reg <= in_byte;
    end
    if (cmd.mant_start) begin
      mantissa       <= VALUE_WIDTH'(digit);
      exponent_count <= 6'd0;
    end else if (cmd.mant_acc) begin
      mantissa <= (mantissa << 3) + (mantissa << 1) + VALUE_WIDTH'(digit);
    end else if (cmd.scale_step) begin
      mantissa       <= (mantissa << 3) + (mantissa << 1);
      exponent_count <= exponent_count - 6'd1;
    end
    if (cmd.exp_load) begin
      exponent_count <= 6'(digit);
    end else if (cmd.exp_acc) begin
      exponent_count <= (exp_mul > 10'(EXP_CAP)) ? EXP_CAP : exp_mul[5:0];
    end
    if (cmd.id_start) begin
      ident_chars[0] <= byte_reg;
      ident_length   <= LEN_W'(1);
    end else if (cmd.id_push) begin
      ident_chars[ident_length[IDX_W-1:0]] <= byte_reg;
      ident_length <= ident_length + LEN_W'(1);
    end
    if (cmd.run_clear) begin
      run_idx <= '0;
    end else if (cmd.run_step) begin
      run_idx <= run_idx + IDX_W'(1);
    end
    if (cmd.char_load) begin
      char_literal <= byte_reg;
    end
    if (cmd.emit) begin
      token_kind  <= cmd.kind;
      line_number <= LINE_NUMBER_W'(line_count);
      last        <= cmd.last;
      id_char     <= (cmd.vsel == VS_IDENT) ? run_char : 8'h00;
      case (cmd.vsel)
        VS_NUM:   token_value <= TOKEN_VALUE_W'(mantissa);
        VS_CHAR:  token_value <= TOKEN_VALUE_W'(char_literal);
        VS_IDENT: token_value <= TOKEN_VALUE_W'(ident_length);
        default:  token_value <= '0;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pslex_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pslex_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  pslex_pkg::status_t status,
  output pslex_pkg::cmd_t    cmd
);
  import pslex_pkg::*;

  // Sequencing phases.
  typedef enum logic [6:0] {
    PH_WAIT  = 7'b0000001,
    PH_MODE  = 7'b0000010,
    PH_SCALE = 7'b0000100,
    PH_IDOUT = 7'b0001000,
    PH_START = 7'b0010000,
    PH_HALT  = 7'b0100000,
    PH_RUN0  = 7'b1000000
  } phase_t;

  // Lexical scan modes.
  typedef enum logic [12:0] {
    M_IDLE     = 13'b0000000000001,
    M_PAREN    = 13'b0000000000010,
    M_COMMENT  = 13'b0000000000100,
    M_NUM      = 13'b0000000001000,
    M_NUM_D    = 13'b0000000010000,
    M_NUM_PLUS = 13'b0000000100000,
    M_NUM_EXP  = 13'b0000001000000,
    M_IDENT    = 13'b0000010000000,
    M_QUOTE    = 13'b0000100000000,
    M_QCHAR    = 13'b0001000000000,
    M_COLON    = 13'b0010000000000,
    M_GT       = 13'b0100000000000,
    M_LT       = 13'b1000000000000
  } mode_t;

  phase_t     phase, phase_next;
  mode_t      mode, mode_next;
  logic       star_seen, star_seen_next;
  logic [7:0] b;
  logic       is_digit, is_alpha;

  // Start-of-token decode.
  logic       s_emit, s_halt, s_inc, s_mant, s_id;
  logic [5:0] s_kind;
  mode_t      s_mode;

  assign b        = status.byte_val;
  assign is_digit = (b >= "0") && (b <= "9");
  assign is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  assign in_stall = !((phase == PH_WAIT) || (phase == PH_HALT));

  // Decode of a byte that begins a token.
  always_comb begin
    s_emit = 1'b0;
    s_halt = 1'b0;
    s_inc  = 1'b0;
    s_mant = 1'b0;
    s_id   = 1'b0;
    s_kind = K_ERROR;
    s_mode = M_IDLE;
    case (b) inside
      "\n":      s_inc = 1'b1;
      " ", "\t": s_inc = 1'b0;
      8'h00: begin
        s_emit = 1'b1;
        s_kind = K_END;
        s_halt = 1'b1;
      end
      "'": s_mode = M_QUOTE;
      "(": s_mode = M_PAREN;
      ":": s_mode = M_COLON;
      ">": s_mode = M_GT;
      "<": s_mode = M_LT;
      "+": begin s_emit = 1'b1; s_kind = K_PLUS;  end
      "-": begin s_emit = 1'b1; s_kind = K_MINUS; end
      "*": begin s_emit = 1'b1; s_kind = K_STAR;  end
      ";": begin s_emit = 1'b1; s_kind = K_SEMI;  end
      ")": begin s_emit = 1'b1; s_kind = K_RPAR;  end
      ".": begin s_emit = 1'b1; s_kind = K_DOT;   end
      ",": begin s_emit = 1'b1; s_kind = K_COMMA; end
      "=": begin s_emit = 1'b1; s_kind = K_EQ;    end
      default: begin
        if (is_digit) begin
          s_mant = 1'b1;
          s_mode = M_NUM;
        end else if (is_alpha) begin
          s_id   = 1'b1;
          s_mode = M_IDENT;
        end else begin
          s_emit = 1'b1;
          s_kind = K_ERROR;
          s_halt = 1'b1;
        end
      end
    endcase
  end

  // Next phase, next mode and datapath commands.
  always_comb begin
    phase_next     = phase;
    mode_next      = mode;
    star_seen_next = star_seen;
    cmd            = '0;
    cmd.vsel       = VS_ZERO;
    cmd.kind       = K_ERROR;
    cmd.last       = 1'b1;

    unique case (phase)
      PH_WAIT: begin
        if (in_valid) begin
          phase_next = PH_MODE;
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      PH_SCALE: begin
        if (status.exp_zero) begin
          cmd.emit   = 1'b1;
          cmd.kind   = K_NUMBER;
          cmd.vsel   = VS_NUM;
          phase_next = PH_START;
        end else begin
          cmd.scale_step = 1'b1;
        end
      end
      PH_RUN0: begin
        cmd.run_clear = 1'b1;
        phase_next    = PH_IDOUT;
      end
      PH_IDOUT: begin
        cmd.emit = 1'b1;
        if (status.kw_kind != K_IDENT) begin
          cmd.kind   = status.kw_kind;
          phase_next = PH_START;
        end else begin
          cmd.kind     = K_IDENT;
          cmd.vsel     = VS_IDENT;
          cmd.last     = status.run_last;
          cmd.run_step = 1'b1;
          if (status.run_last) begin
            phase_next = PH_START;
          end
        end
      end
      PH_START: begin
        cmd.emit       = s_emit;
        cmd.kind       = s_kind;
        cmd.line_inc   = s_inc;
        cmd.mant_start = s_mant;
        cmd.id_start   = s_id;
        mode_next      = s_mode;
        phase_next     = s_halt ? PH_HALT : PH_WAIT;
      end
      PH_MODE: begin
        phase_next = PH_WAIT;
        unique case (mode)
          M_IDLE: begin
            cmd.emit       = s_emit;
            cmd.kind       = s_kind;
            cmd.line_inc   = s_inc;
            cmd.mant_start = s_mant;
            cmd.id_start   = s_id;
            mode_next      = s_mode;
            phase_next     = s_halt ? PH_HALT : PH_WAIT;
          end
          M_PAREN: begin
            if (b == "*") begin
              mode_next      = M_COMMENT;
              star_seen_next = 1'b0;
            end else begin
              cmd.emit   = 1'b1;
              cmd.kind   = K_LPAR;
              mode_next  = M_IDLE;
              phase_next = PH_START;
            end
          end
          M_COMMENT: begin
            if (b == 8'h00) begin
              cmd.emit   = 1'b1;
              mode_next  = M_IDLE;
              phase_next = PH_HALT;
            end else if (star_seen && (b == ")")) begin
              cmd.emit       = 1'b1;
              cmd.kind       = K_COMMENT;
              star_seen_next = 1'b0;
              mode_next      = M_IDLE;
            end else begin
              star_seen_next = (b == "*");
            end
          end
          M_NUM: begin
            if (is_digit) begin
              cmd.mant_acc = 1'b1;
            end else if ((b == "d") || (b == "D")) begin
              mode_next = M_NUM_D;
            end else begin
              mode_next  = M_IDLE;
              phase_next = PH_SCALE;
            end
          end
          M_NUM_D, M_NUM_PLUS: begin
            if ((mode == M_NUM_D) && (b == "+")) begin
              mode_next = M_NUM_PLUS;
            end else if (is_digit) begin
              cmd.exp_load = 1'b1;
              mode_next    = M_NUM_EXP;
            end else begin
              cmd.emit   = 1'b1;
              mode_next  = M_IDLE;
              phase_next = PH_HALT;
            end
          end
          M_NUM_EXP: begin
            if (is_digit) begin
              cmd.exp_acc = 1'b1;
            end else begin
              mode_next  = M_IDLE;
              phase_next = PH_SCALE;
            end
          end
          M_IDENT: begin
            if (is_digit || is_alpha) begin
              if (status.id_full) begin
                cmd.emit   = 1'b1;
                mode_next  = M_IDLE;
                phase_next = PH_HALT;
              end else begin
                cmd.id_push = 1'b1;
              end
            end else begin
              mode_next  = M_IDLE;
              phase_next = PH_RUN0;
            end
          end
          M_QUOTE: begin
            if ((b == "'") || (b == 8'h00) || (b == "\n")) begin
              cmd.emit   = 1'b1;
              mode_next  = M_IDLE;
              phase_next = PH_HALT;
            end else begin
              cmd.char_load = 1'b1;
              mode_next     = M_QCHAR;
            end
          end
          M_QCHAR: begin
            cmd.emit  = 1'b1;
            mode_next = M_IDLE;
            if (b == "'") begin
              cmd.kind = K_CHAR;
              cmd.vsel = VS_CHAR;
            end else begin
              phase_next = PH_HALT;
            end
          end
          M_COLON: begin
            cmd.emit  = 1'b1;
            mode_next = M_IDLE;
            if (b == "=") begin
              cmd.kind = K_ASSIGN;
            end else begin
              cmd.kind   = K_COLON;
              phase_next = PH_START;
            end
          end
          M_GT: begin
            cmd.emit  = 1'b1;
            mode_next = M_IDLE;
            if (b == "=") begin
              cmd.kind = K_GE;
            end else begin
              cmd.kind   = K_GT;
              phase_next = PH_START;
            end
          end
          M_LT: begin
            cmd.emit  = 1'b1;
            mode_next = M_IDLE;
            if (b == ">") begin
              cmd.kind = K_NE;
            end else if (b == "=") begin
              cmd.kind = K_LE;
            end else begin
              cmd.kind   = K_LT;
              phase_next = PH_START;
            end
          end
          default: begin
            mode_next = M_IDLE;
          end
        endcase
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase

    // A result waits while the output register is still full.
    if (cmd.emit && !status.out_free) begin
      cmd            = '0;
      cmd.vsel       = VS_ZERO;
      cmd.kind       = K_ERROR;
      cmd.last       = 1'b1;
      phase_next     = phase;
      mode_next      = mode;
      star_seen_next = star_seen;
    end

    // Byte capture on an input transfer.
    cmd.load_byte = in_valid && (phase == PH_WAIT);
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      mode      <= M_IDLE;
      star_seen <= 1'b0;
    end else begin
      phase     <= phase_next;
      mode      <= mode_next;
      star_seen <= star_seen_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pascal_subset_lexer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming lexer for a small Pascal-like language. Source bytes enter one
// per transfer on in_byte (zero ends the text); tokens leave as results with
// kind, starting line, value, identifier character and a last flag, and an
// identifier leaves as one result per character. A byte that causes no
// result is captured and then decoded in the scan controller. A byte that
// closes a pending token and starts another is decoded a second time as the
// start of a token. A byte that closes a number first goes to the scale
// phase, where the shift-add scaler multiplies the mantissa by ten once a
// cycle for each power of ten in its exponent (up to 63 steps) before the
// number is reported. A byte that closes an identifier passes a setup step,
// then gives one result for a keyword or one per character otherwise. A
// result waits while the output register is full and stalled. After an
// error or the end of text the block keeps taking bytes and reports nothing
// until reset. Writing cfg_data with cfg_write loads the line counter.
module pascal_subset_lexer_core #(
  parameter int MAX_ID_LEN  = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int LINE_WIDTH  = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [7:0]   in_byte,
  input  wire         cfg_write,
  input  wire [15:0]  cfg_data,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [5:0]  token_kind,
  output logic [15:0] line_number,
  output logic [31:0] token_value,
  output logic [7:0]  id_char,
  output logic        last
);
  import pslex_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Scan controller.
  pslex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Token datapath and output register.
  pslex_dp #(
    .MAX_ID_LEN  (MAX_ID_LEN),
    .VALUE_WIDTH (VALUE_WIDTH),
    .LINE_WIDTH  (LINE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .token_kind  (token_kind),
    .line_number (line_number),
    .token_value (token_value),
    .id_char     (id_char),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== sim/pascal_subset_lexer_core_tb.sv =====
`timescale 1ns / 1ps
module pascal_subset_lexer_core_tb;
  import pslex_pkg::*;

  // Cycles the block may still need after its last result (scaling plus idle margin).
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;

  typedef enum int {
    S_IDLE, S_PAREN, S_COMMENT, S_NUM, S_NUM_D, S_NUM_PLUS, S_NUM_EXP,
    S_IDENT, S_QUOTE, S_QCHAR, S_COLON, S_GT, S_LT
  } scan_t;

  typedef struct {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [31:0] value;
    logic [7:0]  ch;
    logic        last;
  } token_t;

  typedef struct {
    string       text;
    bit          typed;
    logic [5:0]  kind;
    logic [31:0] value;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  token_kind;
  logic [15:0] line_number;
  logic [31:0] token_value;
  logic [7:0]  id_char;
  logic        last;

  pascal_subset_lexer_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .token_kind(token_kind), .line_number(line_number),
    .token_value(token_value), .id_char(id_char), .last(last)
  );

  always #4 clk = ~clk;

  // Predicted lexer state.
  scan_t       mode;
  logic [15:0] lines;
  logic [7:0]  id_buf [16];
  int          id_len;
  logic [31:0] mant;
  int          expn;
  logic [7:0]  chr;
  bit          star;
  bit          halt;

  token_t      token_q [$];
  int          push_cnt = 0;
  int          errors = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  bit          hold_req = 0;
  int          hold_left = 0;

  string kw_words [20] = '{
    "program", "var", "begin", "end", "if", "then", "else", "while", "do",
    "read", "write", "char", "integer", "boolean", "div", "or", "and",
    "not", "true", "false"
  };
  string op_words [16] = '{
    "+", "-", "*", ";", ":", ":=", "(", ")", ".", ",", "=", ">", ">=", "<",
    "<>", "<="
  };
  string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_let(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic void push_token(logic [5:0] k, logic [31:0] v, logic [7:0] c,
                                     logic l);
    token_q.push_back('{k, lines, v, c, l});
    push_cnt++;
  endfunction

  function automatic void lex_fail();
    halt = 1;
    mode = S_IDLE;
    push_token(K_ERROR, 0, 0, 1);
  endfunction

  function automatic void put_number();
    logic [31:0] v;
    v = mant;
    for (int i = 0; i < expn; i++) v = v * 32'd10;
    push_token(K_NUMBER, v, 0, 1);
  endfunction

  // Keywords win over identifiers; otherwise one result per character.
  function automatic void put_ident();
    bit hit;
    for (int k = 0; k < 20; k++) begin
      hit = (kw_words[k].len() == id_len);
      for (int j = 0; hit && j < id_len; j++) begin
        if (kw_words[k][j] != id_buf[j]) hit = 0;
      end
      if (hit) begin
        push_token(K_KW0 + 6'(k), 0, 0, 1);
        return;
      end
    end
    for (int j = 0; j < id_len; j++) begin
      push_token(K_IDENT, 32'(id_len), id_buf[j], j + 1 == id_len);
    end
  endfunction

  function automatic void begin_token(logic [7:0] b);
    case (b)
      8'h0a: begin
        if (lines != 16'hffff) lines++;
      end
      " ", 8'h09: ;
      8'h00: begin
        halt = 1;
        push_token(K_END, 0, 0, 1);
      end
      "'": mode = S_QUOTE;
      "(": mode = S_PAREN;
      ":": mode = S_COLON;
      ">": mode = S_GT;
      "<": mode = S_LT;
      "+": push_token(K_PLUS, 0, 0, 1);
      "-": push_token(K_MINUS, 0, 0, 1);
      "*": push_token(K_STAR, 0, 0, 1);
      ";": push_token(K_SEMI, 0, 0, 1);
      ")": push_token(K_RPAR, 0, 0, 1);
      ".": push_token(K_DOT, 0, 0, 1);
      ",": push_token(K_COMMA, 0, 0, 1);
      "=": push_token(K_EQ, 0, 0, 1);
      default: begin
        if (is_dig(b)) begin
          mant = 32'(b - "0");
          expn = 0;
          mode = S_NUM;
        end else if (is_let(b)) begin
          id_buf[0] = b;
          id_len = 1;
          mode = S_IDENT;
        end else begin
          lex_fail();
        end
      end
    endcase
  endfunction

  // One accepted source byte: extends or closes a pending token, then may start one.
  function automatic void lex_step(logic [7:0] b);
    if (halt) return;
    case (mode)
      S_PAREN: begin
        if (b == "*") begin
          mode = S_COMMENT;
          star = 0;
          return;
        end
        push_token(K_LPAR, 0, 0, 1);
      end
      S_COMMENT: begin
        if (b == 0) begin
          lex_fail();
        end else if (star && b == ")") begin
          star = 0;
          mode = S_IDLE;
          push_token(K_COMMENT, 0, 0, 1);
        end else begin
          star = (b == "*");
        end
        return;
      end
      S_NUM: begin
        if (is_dig(b)) begin
          mant = mant * 32'd10 + 32'(b - "0");
          return;
        end
        if (b == "d" || b == "D") begin
          mode = S_NUM_D;
          return;
        end
        put_number();
      end
      S_NUM_D, S_NUM_PLUS: begin
        if (mode == S_NUM_D && b == "+") begin
          mode = S_NUM_PLUS;
        end else if (is_dig(b)) begin
          expn = b - "0";
          mode = S_NUM_EXP;
        end else begin
          lex_fail();
        end
        return;
      end
      S_NUM_EXP: begin
        if (is_dig(b)) begin
          expn = expn * 10 + (b - "0");
          if (expn > 63) expn = 63;
          return;
        end
        put_number();
      end
      S_IDENT: begin
        if (is_let(b) || is_dig(b)) begin
          if (id_len >= 16) begin
            lex_fail();
          end else begin
            id_buf[id_len] = b;
            id_len++;
          end
          return;
        end
        put_ident();
      end
      S_QUOTE: begin
        if (b == "'" || b == 0 || b == 8'h0a) begin
          lex_fail();
        end else begin
          chr = b;
          mode = S_QCHAR;
        end
        return;
      end
      S_QCHAR: begin
        if (b != "'") begin
          lex_fail();
        end else begin
          mode = S_IDLE;
          push_token(K_CHAR, 32'(chr), 0, 1);
        end
        return;
      end
      S_COLON: begin
        if (b == "=") begin
          mode = S_IDLE;
          push_token(K_ASSIGN, 0, 0, 1);
          return;
        end
        push_token(K_COLON, 0, 0, 1);
      end
      S_GT: begin
        if (b == "=") begin
          mode = S_IDLE;
          push_token(K_GE, 0, 0, 1);
          return;
        end
        push_token(K_GT, 0, 0, 1);
      end
      S_LT: begin
        if (b == ">" || b == "=") begin
          mode = S_IDLE;
          push_token(b == ">" ? K_NE : K_LE, 0, 0, 1);
          return;
        end
        push_token(K_LT, 0, 0, 1);
      end
      default: ;
    endcase
    mode = S_IDLE;
    begin_token(b);
  endfunction

  // Result side: compare every transfer, then choose the next stall.
  always @(posedge clk) begin
    token_t t;
    if (!rst && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", token_kind);
        errors++;
      end else begin
        t = token_q.pop_front();
        if (token_kind !== t.kind) begin
          $error("token_kind expected %0d got %0d", t.kind, token_kind);
          errors++;
        end
        if (line_number !== t.line) begin
          $error("line_number expected %0d got %0d", t.line, line_number);
          errors++;
        end
        if (token_value !== t.value) begin
          $error("token_value expected %0d got %0d", t.value, token_value);
          errors++;
        end
        if (id_char !== t.ch) begin
          $error("id_char expected %0d got %0d", t.ch, id_char);
          errors++;
        end
        if (last !== t.last) begin
          $error("last expected %0d got %0d", t.last, last);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // Offer one byte; valid stays high after the transfer unless the next call idles.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_step(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_start_line(input logic [15:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    lines = v;
  endtask

  task automatic send_space();
    int n;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_byte(8'h09);
        1: send_byte(8'h0a);
        default: send_byte(" ");
      endcase
    end
  endtask

  // One well-formed token with random content, followed by white space.
  task automatic send_token(input bit ident_only);
    int n;
    logic [7:0] c;
    int sel;
    sel = ident_only ? 0 : $urandom_range(9);
    case (sel)
      0, 1: begin
        if ($urandom_range(3) == 0) begin
          send_text(kw_words[$urandom_range(19)]);
        end else begin
          n = ($urandom_range(7) == 0) ? 16 : $urandom_range(1, 6);
          send_byte(alpha_set[$urandom_range(52)]);
          for (int i = 1; i < n; i++) begin
            if ($urandom_range(3) == 0) send_byte(8'(8'h30 + $urandom_range(9)));
            else send_byte(alpha_set[$urandom_range(52)]);
          end
        end
      end
      2, 3: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send_byte(8'(8'h30 + $urandom_range(9)));
        if ($urandom_range(2) == 0) begin
          send_byte($urandom_range(1) ? "d" : "D");
          if ($urandom_range(1)) send_byte("+");
          n = ($urandom_range(9) == 0) ? 3 : $urandom_range(1, 2);
          for (int i = 0; i < n; i++) send_byte(8'(8'h30 + $urandom_range(9)));
        end
      end
      4: begin
        do c = 8'($urandom_range(1, 255)); while (c == "'" || c == 8'h0a);
        send_byte("'");
        send_byte(c);
        send_byte("'");
      end
      5: begin
        send_text("(*");
        if ($urandom_range(3) == 0) send_byte(")");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(1, 255)); while (c == ")");
          send_byte(c);
        end
        send_text("*)");
      end
      default: send_text(op_words[$urandom_range(15)]);
    endcase
    send_space();
  endtask

  task automatic random_phase(input int tokens, input bit with_hold);
    for (int i = 0; i < tokens; i++) begin
      if (with_hold && i == tokens / 3) begin
        hold_req = 1;
        // Identifier runs fill the output path quickly while the receiver holds off.
        repeat (8) send_token(1);
      end
      if (!with_hold && i == tokens / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (token_q.size() != 0) @(posedge clk);
      end
      send_token(0);
    end
  endtask

  row_t dir_rows [19] = '{
    '{"program ", 1, K_KW0, 0},
    '{"false ", 1, K_KW0 + 6'd19, 0},
    '{"4294967295 ", 1, K_NUMBER, 32'hffffffff},
    '{"0 ", 1, K_NUMBER, 0},
    '{"5d+2 ", 1, K_NUMBER, 500},
    '{"1D99 ", 1, K_NUMBER, 0},
    '{"'a'", 1, K_CHAR, 97},
    '{"(*)\n*) ", 1, K_COMMENT, 0},
    '{":=", 1, K_ASSIGN, 0},
    '{"<>", 1, K_NE, 0},
    '{"<=", 1, K_LE, 0},
    '{">=", 1, K_GE, 0},
    '{"( : < > ; , . = - * + ) ", 0, 0, 0},
    '{"\t\n", 0, 0, 0},
    '{"abcdefghijklmnop ", 0, 0, 0},
    '{"x9_Z 12d3 ", 0, 0, 0},
    '{"var begin end if then else while do read write ", 0, 0, 0},
    '{"char integer boolean div or and not true ", 0, 0, 0},
    '{"' ' (**) ", 0, 0, 0}
  };

  initial begin
    int prior_cnt;
    int pick;
    mode = S_IDLE;
    lines = 16'd1;
    id_len = 0;
    mant = 0;
    expn = 0;
    chr = 0;
    star = 0;
    halt = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, sender sparse idles, receiver mostly stalled.
    snd_idle = 14;
    rcv_idle = 87;
    for (int r = 0; r < 19; r++) begin
      prior_cnt = push_cnt;
      send_text(dir_rows[r].text);
      if (dir_rows[r].typed) begin
        if (push_cnt - prior_cnt != 1) begin
          $error("row %0d gave %0d tokens", r, push_cnt - prior_cnt);
          errors++;
        end else begin
          token_q[$].kind = dir_rows[r].kind;
          token_q[$].value = dir_rows[r].value;
        end
      end
    end
    random_phase(6, 0);

    // Lines from zero, roles of the two sides swapped, one long hold-off.
    set_start_line(16'd0);
    snd_idle = 87;
    rcv_idle = 14;
    random_phase(10, 1);

    // Line counter at its top must not wrap.
    set_start_line(16'hffff);
    snd_idle = 0;
    rcv_idle = 0;
    send_text("\n\nx\n12 ");
    random_phase(6, 0);

    set_start_line(16'($urandom));
    random_phase(3, 0);

    // One stop condition, then bytes that must be ignored.
    pick = $urandom_range(6);
    case (pick)
      0: send_byte(8'h00);
      1: send_byte(8'($urandom_range(128, 255)));
      2: send_text("!");
      3: send_text("aaaaaaaaaaaaaaaaa");
      4: send_text("7d;");
      5: send_text("''");
      default: begin
        send_text("(* x");
        send_byte(8'h00);
      end
    endcase
    repeat (5) send_byte(8'($urandom_range(255)));
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
